FILE: sv/dgpg_pkg.sv
package dgpg_pkg;

  // Default coordinate width of the gradient registers.
  localparam int COORD_BITS_DEFAULT = 11;

  // Configuration port.
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;

  // Stream payloads.
  localparam int ROW_W      = 10;
  localparam int COL_W      = 10;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 8;
  localparam int LEVEL_W    = 2;
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 3;
  localparam int COLOR_W    = CHAN_W * NUM_CHAN;

  // |band - top| * row magnitude: 255 * 1023 stays below 2**18.
  localparam int PROD_W = 18;

  // Register reset values, cut down to the register widths in the core.
  localparam logic [31:0] BAND_ROW_RESET       = 32'd2047;
  localparam logic [31:0] VIRTUAL_HEIGHT_RESET = 32'd228;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TOP_COLOR      = 3'd0,
    REG_BAND_COLOR     = 3'd1,
    REG_HORIZON_COLOR  = 3'd2,
    REG_BAND_ROW       = 3'd3,
    REG_VIRTUAL_TOP    = 3'd4,
    REG_VIRTUAL_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [LEVEL_W-1:0] level_t;

  // Standard 4x4 Bayer matrix, indexed [row mod 4][column mod 4].
  localparam logic [3:0] BAYER4 [4][4] = '{
    '{4'd0,  4'd8,  4'd2,  4'd10},
    '{4'd12, 4'd4,  4'd14, 4'd6},
    '{4'd3,  4'd11, 4'd1,  4'd9},
    '{4'd15, 4'd7,  4'd13, 4'd5}
  };

  // Dither threshold on the 0..254 remainder scale: index * 255 / 16.
  function automatic chan_t dither_threshold(input logic [1:0] r, input logic [1:0] c);
    logic [3:0]  idx;
    logic [11:0] scaled;
    idx    = BAYER4[r][c];
    scaled = {idx, 8'd0} - {8'd0, idx};
    return scaled[11:4];
  endfunction

  // Reduce an 8-bit channel to a 2-bit level: c * 3 / 255, rounded up when
  // the remainder passes the threshold and the level is not already full.
  function automatic level_t dither_level(input chan_t c, input chan_t thr);
    logic [9:0] scaled;
    logic [9:0] rem;
    level_t     lvl;
    logic       bump;
    scaled = {2'b00, c} + {1'b0, c, 1'b0};
    if (scaled >= 10'd765) begin
      lvl = 2'd3;
      rem = '0;
    end else if (scaled >= 10'd510) begin
      lvl = 2'd2;
      rem = scaled - 10'd510;
    end else if (scaled >= 10'd255) begin
      lvl = 2'd1;
      rem = scaled - 10'd255;
    end else begin
      lvl = 2'd0;
      rem = scaled;
    end
    bump = (lvl != 2'd3) && (rem > {2'b00, thr});
    return lvl + {1'b0, bump};
  endfunction

endpackage

FILE: sv/dithered_gradient_pixel_generator_core.sv
// Dithered gradient pixel generator. Each transfer on the slave stream carries one pixel
// position (row of the painted area, column) and yields exactly one transfer on the master
// stream with that pixel's red, green and blue levels, each 0 to 3. The colour follows a
// vertical gradient from top_color to band_color at band_row and on to horizon_color at the
// bottom of the virtual span that starts at virtual_top and is virtual_height rows tall;
// each channel is then ordered-dithered with a 4x4 Bayer matrix picked by row and column
// mod 4. The core is a 26-stage pipeline that takes one pixel every clock while the
// master side does not stall. Most of those stages form the 18-stage restoring divider
// that works one quotient bit per stage on all three channels at once. A stall on the
// master side holds the pipeline and fills its bubbles, so the slave side keeps taking
// pixels as long as any stage is empty. Configuration registers are written through
// cfg_wr_en, cfg_index and cfg_data and must only change while no pixel is in flight.
// Register indexes: 0 top_color, 1 band_color, 2 horizon_color, 3 band_row,
// 4 virtual_top, 5 virtual_height; other indexes are ignored.
module dithered_gradient_pixel_generator_core #(
  parameter int COORD_BITS = dgpg_pkg::COORD_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port.
  input  logic                             cfg_wr_en,
  input  logic [dgpg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dgpg_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Pixel positions in.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [dgpg_pkg::S_TDATA_W-1:0]   s_tdata,   // row [9:0], column [19:10], zero [23:20]
  // Pixel levels out.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [dgpg_pkg::M_TDATA_W-1:0]   m_tdata    // red [1:0], green [3:2], blue [5:4], zero [7:6]
);

  import dgpg_pkg::*;

  // Signed width for all coordinate arithmetic; wide enough that nothing wraps and that
  // a 10-bit row stays positive.
  localparam int CW          = COORD_BITS + 4;
  localparam int DIV_STAGES  = PROD_W;

  localparam logic [COORD_BITS:0]   BandRowRst = BAND_ROW_RESET[COORD_BITS:0];
  localparam logic [COORD_BITS-1:0] VirtHeightRst = VIRTUAL_HEIGHT_RESET[COORD_BITS-1:0];
  localparam logic [COORD_BITS-1:0] DenOne = {{(COORD_BITS-1){1'b0}}, 1'b1};

  // ---------------------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------------------
  logic [COLOR_W-1:0]    top_color;
  logic [COLOR_W-1:0]    band_color;
  logic [COLOR_W-1:0]    horizon_color;
  logic [COORD_BITS:0]   band_row;
  logic [COORD_BITS-1:0] virtual_top;
  logic [COORD_BITS-1:0] virtual_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_color      <= '0;
      band_color     <= '0;
      horizon_color  <= '0;
      band_row       <= BandRowRst;
      virtual_top    <= '0;
      virtual_height <= VirtHeightRst;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_TOP_COLOR:      top_color      <= cfg_data[COLOR_W-1:0];
        REG_BAND_COLOR:     band_color     <= cfg_data[COLOR_W-1:0];
        REG_HORIZON_COLOR:  horizon_color  <= cfg_data[COLOR_W-1:0];
        REG_BAND_ROW:       band_row       <= cfg_data[COORD_BITS:0];
        REG_VIRTUAL_TOP:    virtual_top    <= cfg_data[COORD_BITS-1:0];
        REG_VIRTUAL_HEIGHT: virtual_height <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Registers widened to the common signed coordinate width, read directly by every stage.
  // The user must keep them stable while any pixel is in flight; the core does not enforce it.
  logic signed [CW-1:0] vt_ext;
  logic signed [CW-1:0] vh_ext;
  logic signed [CW-1:0] band_ext;

  assign vt_ext   = {{(CW-COORD_BITS){virtual_top[COORD_BITS-1]}}, virtual_top};
  assign vh_ext   = {{(CW-COORD_BITS){1'b0}}, virtual_height};
  assign band_ext = {{(CW-COORD_BITS-1){band_row[COORD_BITS]}}, band_row};

  // ---------------------------------------------------------------------------------------
  // Pipeline registers and stage enables. A stage loads whenever it is empty or the stage
  // after it loads, so a stall only holds stages that carry a pixel.
  // ---------------------------------------------------------------------------------------
  logic                 s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, c_valid;
  logic                 en1, en2, en3, en4, en5, en_c, en_out;
  logic [DIV_STAGES:0]  dv_en;

  logic [ROW_W-1:0]     s1_row, s2_row, s3_row;
  logic [1:0]           s1_col, s2_col, s3_col;
  logic signed [CW-1:0] s1_vbot, s2_vbot;
  logic signed [CW-1:0] s2_band;
  logic signed [CW-1:0] s3_upper, s3_lower;

  chan_t                s4_thr;
  logic                 s4_lower_br;
  logic [ROW_W-1:0]     s4_num;
  logic [COORD_BITS-1:0] s4_den;

  chan_t                s5_thr;
  logic [ROW_W-1:0]     s5_num;
  logic [COORD_BITS-1:0] s5_den;
  chan_t [NUM_CHAN-1:0] s5_a;
  logic [NUM_CHAN-1:0]  s5_neg;
  chan_t [NUM_CHAN-1:0] s5_dmag;

  // Divider stages: index 0 holds the products, index i has i quotient bits done.
  logic                                  dv_valid [DIV_STAGES+1];
  chan_t                                 dv_thr   [DIV_STAGES+1];
  logic [COORD_BITS-1:0]                 dv_den   [DIV_STAGES+1];
  chan_t [NUM_CHAN-1:0]                  dv_a     [DIV_STAGES+1];
  logic [NUM_CHAN-1:0]                   dv_neg   [DIV_STAGES+1];
  logic [NUM_CHAN-1:0][PROD_W-1:0]       dv_n     [DIV_STAGES+1];
  logic [NUM_CHAN-1:0][COORD_BITS-1:0]   dv_rem   [DIV_STAGES+1];
  logic [NUM_CHAN-1:0][PROD_W-1:0]       dv_q     [DIV_STAGES+1];

  chan_t                c_thr;
  chan_t [NUM_CHAN-1:0] c_chan;

  assign en_out   = !m_tvalid || m_tready;
  assign en_c     = !c_valid || en_out;
  assign dv_en[DIV_STAGES] = !dv_valid[DIV_STAGES] || en_c;
  assign en5      = !s5_valid || dv_en[0];
  assign en4      = !s4_valid || en5;
  assign en3      = !s3_valid || en4;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign s_tready = en1;

  // ---------------------------------------------------------------------------------------
  // Stage 1: take the pixel and form the bottom row of the virtual span.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_row  <= s_tdata[ROW_W-1:0];
      s1_col  <= s_tdata[ROW_W +: 2];
      s1_vbot <= vt_ext + vh_ext - CW'(1);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 2: clamp the band row to the bottom first, then to the top. With an empty span
  // the bottom lies above the top and the band lands on the top row.
  // ---------------------------------------------------------------------------------------
  logic signed [CW-1:0] band_lim;
  logic signed [CW-1:0] band_clamp;

  always_comb begin
    band_lim   = (band_ext > s1_vbot) ? s1_vbot : band_ext;
    band_clamp = (band_lim < vt_ext) ? vt_ext : band_lim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_row  <= s1_row;
      s2_col  <= s1_col;
      s2_vbot <= s1_vbot;
      s2_band <= band_clamp;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 3: lengths of the upper and lower spans. The lower one is negative for an
  // empty span.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_row   <= s2_row;
      s3_col   <= s2_col;
      s3_upper <= s2_band - vt_ext;
      s3_lower <= s2_vbot - s2_band;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 4: pick the half of the gradient. The virtual row lies at or above the band
  // exactly when the painted row is at most the upper span. Spans that are not positive
  // divide by one.
  // ---------------------------------------------------------------------------------------
  logic signed [CW-1:0] row_ext;
  logic signed [CW-1:0] row_past;
  logic signed [CW-1:0] den_sel;
  logic                 lower_br;

  always_comb begin
    row_ext  = {{(CW-ROW_W){1'b0}}, s3_row};
    row_past = row_ext - s3_upper;
    lower_br = row_ext > s3_upper;
    den_sel  = lower_br ? s3_lower : s3_upper;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en4) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_thr      <= dither_threshold(s3_row[1:0], s3_col);
      s4_lower_br <= lower_br;
      s4_num      <= lower_br ? row_past[ROW_W-1:0] : s3_row;
      s4_den      <= (!den_sel[CW-1] && (den_sel != '0)) ? den_sel[COORD_BITS-1:0] : DenOne;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 5: end colours of the chosen half and the per-channel step, kept as sign and
  // magnitude for the unsigned divider. Red sits in the top byte.
  // ---------------------------------------------------------------------------------------
  logic [COLOR_W-1:0]   from_color;
  logic [COLOR_W-1:0]   to_color;
  chan_t [NUM_CHAN-1:0] a_w;
  logic [NUM_CHAN-1:0]  neg_w;
  chan_t [NUM_CHAN-1:0] mag_w;

  always_comb begin
    logic [CHAN_W:0] diff;
    diff       = '0;
    from_color = s4_lower_br ? band_color : top_color;
    to_color   = s4_lower_br ? horizon_color : band_color;
    for (int k = 0; k < NUM_CHAN; k++) begin
      a_w[k]   = from_color[COLOR_W-CHAN_W*(k+1) +: CHAN_W];
      diff     = {1'b0, to_color[COLOR_W-CHAN_W*(k+1) +: CHAN_W]} - {1'b0, a_w[k]};
      neg_w[k] = diff[CHAN_W];
      mag_w[k] = diff[CHAN_W] ? chan_t'(~diff[CHAN_W-1:0] + 1'b1) : diff[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en5) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_thr  <= s4_thr;
      s5_num  <= s4_num;
      s5_den  <= s4_den;
      s5_a    <= a_w;
      s5_neg  <= neg_w;
      s5_dmag <= mag_w;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 6 (divider entry): step magnitude times distance into the span.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (dv_en[0]) begin
      dv_valid[0] <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_en[0]) begin
      dv_thr[0] <= s5_thr;
      dv_den[0] <= s5_den;
      dv_a[0]   <= s5_a;
      dv_neg[0] <= s5_neg;
      for (int k = 0; k < NUM_CHAN; k++) begin
        dv_n[0][k]   <= {{(PROD_W-CHAN_W){1'b0}}, s5_dmag[k]} *
                        {{(PROD_W-ROW_W){1'b0}}, s5_num};
        dv_rem[0][k] <= '0;
        dv_q[0][k]   <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Restoring divider: each stage shifts in the next dividend bit and subtracts the
  // divisor when it fits, producing one quotient bit per channel.
  // ---------------------------------------------------------------------------------------
  for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_div
    logic [NUM_CHAN-1:0][COORD_BITS-1:0] rem_w;
    logic [NUM_CHAN-1:0]                 qbit_w;

    assign dv_en[i-1] = !dv_valid[i-1] || dv_en[i];

    always_comb begin
      logic [COORD_BITS:0] r_try;
      logic [COORD_BITS:0] r_sub;
      r_try = '0;
      r_sub = '0;
      for (int k = 0; k < NUM_CHAN; k++) begin
        r_try     = {dv_rem[i-1][k], dv_n[i-1][k][PROD_W-1]};
        r_sub     = r_try - {1'b0, dv_den[i-1]};
        qbit_w[k] = r_try >= {1'b0, dv_den[i-1]};
        rem_w[k]  = qbit_w[k] ? r_sub[COORD_BITS-1:0] : r_try[COORD_BITS-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[i] <= 1'b0;
      end else if (dv_en[i]) begin
        dv_valid[i] <= dv_valid[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (dv_en[i]) begin
        dv_thr[i] <= dv_thr[i-1];
        dv_den[i] <= dv_den[i-1];
        dv_a[i]   <= dv_a[i-1];
        dv_neg[i] <= dv_neg[i-1];
        dv_rem[i] <= rem_w;
        for (int k = 0; k < NUM_CHAN; k++) begin
          dv_n[i][k] <= {dv_n[i-1][k][PROD_W-2:0], 1'b0};
          dv_q[i][k] <= {dv_q[i-1][k][PROD_W-2:0], qbit_w[k]};
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage C: apply the sign to the quotient (truncation toward zero) and add it to the
  // start colour. Only the low byte is kept, so rows past the span wrap.
  // ---------------------------------------------------------------------------------------
  chan_t [NUM_CHAN-1:0] chan_w;

  always_comb begin
    chan_t qlow;
    qlow = '0;
    for (int k = 0; k < NUM_CHAN; k++) begin
      qlow      = dv_q[DIV_STAGES][k][CHAN_W-1:0];
      chan_w[k] = dv_a[DIV_STAGES][k] + (dv_neg[DIV_STAGES][k] ? chan_t'(~qlow + 1'b1) : qlow);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en_c) begin
      c_valid <= dv_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_thr  <= dv_thr[DIV_STAGES];
      c_chan <= chan_w;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Output stage: ordered dither to two bits per channel.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_out) begin
      m_tvalid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      m_tdata <= {2'b00,
                  dither_level(c_chan[2], c_thr),
                  dither_level(c_chan[1], c_thr),
                  dither_level(c_chan[0], c_thr)};
    end
  end

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------

  // With the output register empty every stage may load, so the core must take pixels.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("slave side stalled while the output register is empty");

  // The band clamp keeps the band at or below the top, so the upper span never goes
  // negative.
  a_upper_nonneg: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> !s3_upper[CW-1])
    else $error("upper span negative after band clamp");

  // Empty spans are replaced by one before division.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    dv_valid[0] |-> (dv_den[0] != '0))
    else $error("zero divisor entered the divider");

  // A finished division leaves a remainder below the divisor in every channel.
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    dv_valid[DIV_STAGES] |->
      (dv_rem[DIV_STAGES][0] < dv_den[DIV_STAGES]) &&
      (dv_rem[DIV_STAGES][1] < dv_den[DIV_STAGES]) &&
      (dv_rem[DIV_STAGES][2] < dv_den[DIV_STAGES]))
    else $error("divider remainder not below divisor");

endmodule
